// ===== rtl/tws_pkg.sv =====
// shared types, constants and a helper function for the two-window report schedule
// no dependencies; every other rtl file imports this package
package tws_pkg;

   localparam int unsigned NUM_STAGES = 12;

   localparam logic [16:0] DAY_SECONDS     = 17'd86400;
   localparam logic [11:0] DAY_MINUTES     = 12'd1440;
   localparam logic [10:0] MAX_START       = 11'd1439;
   localparam logic [5:0]  INTERVAL_LOW    = 6'd5;
   localparam logic [5:0]  INTERVAL_HIGH   = 6'd60;
   localparam logic [11:0] MIN_SPAN        = 12'd30;

   // 86400 = 128 * 675; the remainder by 675 is folded down then finished by reciprocal
   localparam logic [22:0] FOLD_HI_MOD     = 23'd61;     // 2^16 mod 675
   localparam logic [16:0] FOLD_MID_MOD    = 17'd46;     // 2^12 mod 675
   localparam logic [33:0] RECIP_675       = 34'd99420;  // floor(2^26 / 675)
   localparam logic [16:0] DIVISOR_675     = 17'd675;
   localparam logic [30:0] RECIP_15        = 31'd34953;  // ceil(2^19 / 15)

   localparam logic [10:0] RESET_W0_START    = 11'd360;
   localparam logic [5:0]  RESET_W0_INTERVAL = 6'd15;
   localparam logic [10:0] RESET_W1_START    = 11'd1320;
   localparam logic [5:0]  RESET_W1_INTERVAL = 6'd5;

   typedef enum logic [1:0] {
      CSR_W0_START    = 2'd0,
      CSR_W0_INTERVAL = 2'd1,
      CSR_W1_START    = 2'd2,
      CSR_W1_INTERVAL = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [39:0] wall_seconds;
      logic        window_sel;
      logic [8:0]  slot_number;
   } req_type;

   typedef struct packed {
      logic        active_window;
      logic [8:0]  slot_ordinal;
      logic [20:0] slot_due_offset;
      logic [40:0] next_due_seconds;
      logic        config_valid;
   } rsp_type;

   typedef struct packed {
      logic [10:0] w0_start;
      logic [5:0]  w0_interval;
      logic [10:0] w1_start;
      logic [5:0]  w1_interval;
   } cfg_type;

   // one restoring division step; state is {remainder[5:0], dividend/quotient[10:0]}
   function automatic logic [16:0] div_step(input logic [16:0] st, input logic [5:0] dvs);
      logic [6:0] trial;
      logic [6:0] diff;
      trial = {st[16:11], st[10]};
      diff  = trial - {1'b0, dvs};
      if (trial >= {1'b0, dvs}) begin
         div_step = {diff[5:0], st[9:0], 1'b1};
      end else begin
         div_step = {trial[5:0], st[9:0], 1'b0};
      end
   endfunction

endpackage

// ===== rtl/tws_day_split.sv =====
// five-stage split of wall seconds into day base, seconds of day and minute of day
// depends on tws_pkg
module tws_day_split (
   input  logic        clock,
   input  logic [4:0]  stage_en,
   input  logic [39:0] wall_seconds,
   output logic [16:0] rem_sec,
   output logic [10:0] minute,
   output logic [39:0] day_base
);
   import tws_pkg::*;

   logic [39:0] wall0_ff, wall1_ff, wall2_ff, wall3_ff;
   logic [22:0] v1_ff, v1_in;
   logic [16:0] v2_ff, v2_in, v2b_ff;
   logic [7:0]  qh_ff, qh_in;
   logic [33:0] recip_prod;
   logic [16:0] r_ff, r_in, sub_val, rm_val;
   logic [30:0] min_prod;
   logic [16:0] rem_ff;
   logic [10:0] minute_ff, minute_in;
   logic [39:0] base_ff, base_in;

   always_comb begin
      // fold the upper bits of wall/128 using 2^16 mod 675
      v1_in = 23'(wall_seconds[39:23]) * FOLD_HI_MOD + 23'(wall_seconds[22:7]);
      v2_in = 17'(v1_ff[22:12]) * FOLD_MID_MOD + 17'(v1_ff[11:0]);
      recip_prod = 34'(v2_ff) * RECIP_675;
      qh_in = recip_prod[33:26];
      // estimate is low by at most one
      sub_val = v2b_ff - 17'(qh_ff) * DIVISOR_675;
      rm_val  = (sub_val >= DIVISOR_675) ? sub_val - DIVISOR_675 : sub_val;
      r_in    = {rm_val[9:0], wall2_ff[6:0]};
      min_prod  = 31'(r_ff[16:2]) * RECIP_15;
      minute_in = min_prod[29:19];
      base_in   = wall3_ff - 40'(r_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         wall0_ff <= wall_seconds;
         v1_ff    <= v1_in;
      end
      if (stage_en[1]) begin
         wall1_ff <= wall0_ff;
         v2_ff    <= v2_in;
      end
      if (stage_en[2]) begin
         wall2_ff <= wall1_ff;
         v2b_ff   <= v2_ff;
         qh_ff    <= qh_in;
      end
      if (stage_en[3]) begin
         wall3_ff <= wall2_ff;
         r_ff     <= r_in;
      end
      if (stage_en[4]) begin
         rem_ff    <= r_ff;
         minute_ff <= minute_in;
         base_ff   <= base_in;
      end
   end

   assign rem_sec  = rem_ff;
   assign minute   = minute_ff;
   assign day_base = base_ff;

endmodule

// ===== rtl/tws_div.sv =====
// three-stage restoring divider, 11-bit dividend by 6-bit divisor
// depends on tws_pkg for the step function
module tws_div (
   input  logic        clock,
   input  logic [2:0]  stage_en,
   input  logic [10:0] dividend,
   input  logic [5:0]  divisor,
   output logic [10:0] quotient
);
   import tws_pkg::*;

   localparam int unsigned STEPS_A = 4;
   localparam int unsigned STEPS_B = 4;
   localparam int unsigned STEPS_C = 3;

   logic [16:0] st0_ff, st0_in, st1_ff, st1_in, st2_ff, st2_in;
   logic [5:0]  dvs0_ff, dvs1_ff;

   always_comb begin
      st0_in = {6'd0, dividend};
      for (int j = 0; j < STEPS_A; j++) begin
         st0_in = div_step(st0_in, divisor);
      end
      st1_in = st0_ff;
      for (int j = 0; j < STEPS_B; j++) begin
         st1_in = div_step(st1_in, dvs0_ff);
      end
      st2_in = st1_ff;
      for (int j = 0; j < STEPS_C; j++) begin
         st2_in = div_step(st2_in, dvs1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         st0_ff  <= st0_in;
         dvs0_ff <= divisor;
      end
      if (stage_en[1]) begin
         st1_ff  <= st1_in;
         dvs1_ff <= dvs0_ff;
      end
      if (stage_en[2]) begin
         st2_ff <= st2_in;
      end
   end

   assign quotient = st2_ff[10:0];

endmodule

// ===== rtl/tws_due_select.sv =====
// two-stage next-due selection: per-window candidates, then earliest offset from day base
// depends on tws_pkg
module tws_due_select (
   input  logic             clock,
   input  logic [1:0]       stage_en,
   input  tws_pkg::cfg_type cfg,
   input  logic [1:0]       first_hit,
   input  logic [10:0]      quot0,
   input  logic [10:0]      quot1,
   input  logic [16:0]      rem_sec,
   output logic [17:0]      best_off
);
   import tws_pkg::*;

   logic [17:0] cm0_ff, cm0_in, cm1_ff, cm1_in;
   logic [16:0] r_ff;
   logic [17:0] best_ff, best_in;
   logic [23:0] off0, off1;
   logic [17:0] limit;
   logic        ok0, ok1;
   logic [10:0] smin;
   logic [16:0] toff;

   always_comb begin
      // candidate minute past midnight for each window
      cm0_in = first_hit[0] ? 18'(cfg.w0_start)
             : 18'(cfg.w0_start) + 18'(12'(quot0) + 12'd1) * 18'(cfg.w0_interval);
      cm1_in = first_hit[1] ? 18'(cfg.w1_start)
             : 18'(cfg.w1_start) + 18'(12'(quot1) + 12'd1) * 18'(cfg.w1_interval);

      off0  = 24'(cm0_ff) * 24'd60;
      off1  = 24'(cm1_ff) * 24'd60;
      limit = 18'(r_ff) + 18'(DAY_SECONDS);
      ok0   = (cfg.w0_interval != 6'd0) && (off0 < 24'(limit));
      ok1   = (cfg.w1_interval != 6'd0) && (off1 < 24'(limit));
      smin  = (cfg.w0_start < cfg.w1_start) ? cfg.w0_start : cfg.w1_start;
      toff  = 17'(smin) * 17'd60;
      if (ok0 && ok1) begin
         best_in = (off0 < off1) ? off0[17:0] : off1[17:0];
      end else if (ok0) begin
         best_in = off0[17:0];
      end else if (ok1) begin
         best_in = off1[17:0];
      end else if (toff < r_ff) begin
         // fall back to tomorrow's earliest window start
         best_in = 18'(DAY_SECONDS) + 18'(toff);
      end else begin
         best_in = limit;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cm0_ff <= cm0_in;
         cm1_ff <= cm1_in;
         r_ff   <= rem_sec;
      end
      if (stage_en[1]) begin
         best_ff <= best_in;
      end
   end

   assign best_off = best_ff;

endmodule

// ===== rtl/two_window_report_schedule.sv =====
// top level of the two-window report schedule: registers, stage control, sideband stages
// depends on tws_pkg, tws_day_split, tws_div, tws_due_select
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   req_data  (tws_pkg::req_type)
//   rsp       out        rsp_valid/rsp_stall   rsp_data  (tws_pkg::rsp_type)
//   csr       in         csr_write             csr_index, csr_wdata
//
// twelve register stages, one request per cycle unless req_stall is high; the stages are the
// day split (5), minute compare (1), divider (3), due select (2) and output (1) stages.
// synchronous reset clears the valid bits and loads the default window registers.
// a stall on rsp holds the output; upstream stages keep filling bubbles, and req_stall
// rises only when every stage holds a request.
module two_window_report_schedule (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tws_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tws_pkg::rsp_type       rsp_data,
   input  logic                   csr_write,
   input  tws_pkg::csr_index_type csr_index,
   input  logic [10:0]            csr_wdata
);
   import tws_pkg::*;

   typedef struct packed {
      logic        win;
      logic [14:0] prod;
      logic [20:0] due;
      logic [39:0] day_base;
      logic [16:0] rem_sec;
      logic        active;
      logic [1:0]  first_hit;
      logic [10:0] ord_diff;
      logic [10:0] gap0;
      logic [10:0] gap1;
      logic [8:0]  ordinal;
   } side_type;

   localparam int unsigned LAST = NUM_STAGES - 1;

   cfg_type              cfg_ff;
   logic [LAST:0]        v_ff;
   logic [LAST:0]        rdy;
   side_type             side_ff [LAST];
   side_type             side_in [LAST];
   rsp_type              rsp_ff, rsp_in;

   logic [16:0] ds_rem_sec;
   logic [10:0] ds_minute;
   logic [39:0] ds_day_base;
   logic [10:0] q_ord, q0, q1;
   logic [17:0] best_off;

   logic [10:0] s1_start, s5_start, mnt;
   logic [5:0]  req_iv, s5_iv, s8_iv;
   logic [15:0] due_sum;
   logic [21:0] due_full;
   logic [12:0] ord_t;
   logic [11:0] span;
   logic        cfg_ok;

   // ready chain: a stage loads when it is empty or its successor moves
   always_comb begin
      rdy[LAST] = !v_ff[LAST] || !rsp_stall;
      for (int k = LAST - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end
   assign req_stall = !rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.w0_start    <= RESET_W0_START;
         cfg_ff.w0_interval <= RESET_W0_INTERVAL;
         cfg_ff.w1_start    <= RESET_W1_START;
         cfg_ff.w1_interval <= RESET_W1_INTERVAL;
      end else if (csr_write) begin
         case (csr_index)
            CSR_W0_START:    cfg_ff.w0_start    <= csr_wdata;
            CSR_W0_INTERVAL: cfg_ff.w0_interval <= csr_wdata[5:0];
            CSR_W1_START:    cfg_ff.w1_start    <= csr_wdata;
            CSR_W1_INTERVAL: cfg_ff.w1_interval <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   tws_day_split u_day_split (
      .clock        (clock),
      .stage_en     (rdy[4:0]),
      .wall_seconds (req_data.wall_seconds),
      .rem_sec      (ds_rem_sec),
      .minute       (ds_minute),
      .day_base     (ds_day_base)
   );

   tws_div u_div_ord (
      .clock    (clock),
      .stage_en (rdy[8:6]),
      .dividend (side_ff[5].ord_diff),
      .divisor  (s5_iv),
      .quotient (q_ord)
   );

   tws_div u_div_w0 (
      .clock    (clock),
      .stage_en (rdy[8:6]),
      .dividend (side_ff[5].gap0),
      .divisor  (cfg_ff.w0_interval),
      .quotient (q0)
   );

   tws_div u_div_w1 (
      .clock    (clock),
      .stage_en (rdy[8:6]),
      .dividend (side_ff[5].gap1),
      .divisor  (cfg_ff.w1_interval),
      .quotient (q1)
   );

   tws_due_select u_due_select (
      .clock     (clock),
      .stage_en  (rdy[10:9]),
      .cfg       (cfg_ff),
      .first_hit (side_ff[8].first_hit),
      .quot0     (q0),
      .quot1     (q1),
      .rem_sec   (side_ff[8].rem_sec),
      .best_off  (best_off)
   );

   always_comb begin
      req_iv    = req_data.window_sel ? cfg_ff.w1_interval : cfg_ff.w0_interval;
      s1_start  = side_ff[0].win ? cfg_ff.w1_start : cfg_ff.w0_start;
      s5_start  = side_ff[4].win ? cfg_ff.w1_start : cfg_ff.w0_start;
      s5_iv     = side_ff[5].win ? cfg_ff.w1_interval : cfg_ff.w0_interval;
      s8_iv     = side_ff[8].win ? cfg_ff.w1_interval : cfg_ff.w0_interval;
      mnt       = ds_minute;

      side_in[0]      = '0;
      side_in[0].win  = req_data.window_sel;
      side_in[0].prod = 15'(req_data.slot_number) * 15'(req_iv);
      for (int k = 1; k < LAST; k++) begin
         side_in[k] = side_ff[k-1];
      end

      due_sum        = 16'(s1_start) + 16'(side_ff[0].prod);
      due_full       = 22'(due_sum) * 22'd60;
      side_in[1].due = due_full[20:0];

      side_in[5].day_base = ds_day_base;
      side_in[5].rem_sec  = ds_rem_sec;
      if (cfg_ff.w1_start > cfg_ff.w0_start) begin
         side_in[5].active = !(mnt >= cfg_ff.w0_start && mnt < cfg_ff.w1_start);
      end else begin
         side_in[5].active = !(mnt >= cfg_ff.w0_start || mnt < cfg_ff.w1_start);
      end
      side_in[5].first_hit[0] = (17'(cfg_ff.w0_start) * 17'd60) >= ds_rem_sec;
      side_in[5].first_hit[1] = (17'(cfg_ff.w1_start) * 17'd60) >= ds_rem_sec;
      // minute offset from the window start, wrapped into one day
      ord_t = 13'(mnt) + 13'(2 * DAY_MINUTES) - 13'(s5_start);
      if (ord_t >= 13'(2 * DAY_MINUTES)) begin
         side_in[5].ord_diff = 11'(ord_t - 13'(2 * DAY_MINUTES));
      end else if (ord_t >= 13'(DAY_MINUTES)) begin
         side_in[5].ord_diff = 11'(ord_t - 13'(DAY_MINUTES));
      end else begin
         side_in[5].ord_diff = 11'(ord_t);
      end
      side_in[5].gap0 = mnt - cfg_ff.w0_start;
      side_in[5].gap1 = mnt - cfg_ff.w1_start;

      if (s8_iv == 6'd0) begin
         side_in[9].ordinal = 9'd0;
      end else if (q_ord > 11'd511) begin
         side_in[9].ordinal = 9'd511;
      end else begin
         side_in[9].ordinal = q_ord[8:0];
      end

      span = (cfg_ff.w1_start > cfg_ff.w0_start)
           ? 12'(cfg_ff.w1_start) - 12'(cfg_ff.w0_start)
           : DAY_MINUTES - 12'(cfg_ff.w0_start) + 12'(cfg_ff.w1_start);
      cfg_ok = (cfg_ff.w0_start <= MAX_START) && (cfg_ff.w1_start <= MAX_START)
            && (cfg_ff.w0_interval inside {[INTERVAL_LOW:INTERVAL_HIGH]})
            && (cfg_ff.w1_interval inside {[INTERVAL_LOW:INTERVAL_HIGH]})
            && (cfg_ff.w0_start != cfg_ff.w1_start) && (span >= MIN_SPAN);

      rsp_in.active_window    = side_ff[LAST-1].active;
      rsp_in.slot_ordinal     = side_ff[LAST-1].ordinal;
      rsp_in.slot_due_offset  = side_ff[LAST-1].due;
      rsp_in.next_due_seconds = 41'(side_ff[LAST-1].day_base) + 41'(best_off);
      rsp_in.config_valid     = cfg_ok;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < LAST; k++) begin
         if (rdy[k]) begin
            side_ff[k] <= side_in[k];
         end
      end
      if (rdy[LAST]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v_ff[LAST];
   assign rsp_data  = rsp_ff;

   // input side only backs up when every stage is occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&v_ff))
      else $error("req_stall with a bubble in the pipeline");

   // a held middle stage keeps its request
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[5] && !rdy[5] |=> v_ff[5] && $stable(side_ff[5]))
      else $error("stage 5 lost or changed a held request");

   // a taken result is not shown again unless a new one arrives behind it
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !v_ff[LAST-1] |=> !rsp_valid)
      else $error("response repeated");

endmodule
